### hw/rtl/mqed_pkg.sv
`default_nettype none

package mqed_pkg;

  localparam int NUM_ENCODERS = 5;
  localparam int PIN_WIDTH    = 16;
  localparam int PINS_PER_ENC = 3;

  localparam logic [2:0] DETENT_RESET   = 3'd4;
  localparam logic [2:0] DEBOUNCE_RESET = 3'd4;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_DETENT_STEPS     = 2'd0;
  localparam logic [1:0] CFG_DEBOUNCE_SAMPLES = 2'd1;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_FWD,
    STEP_REV
  } step_t;

  typedef struct packed {
    logic [2:0] detent_steps;
    logic [2:0] debounce_samples;
  } cfg_t;

  typedef struct packed {
    logic cw;
    logic ccw;
    logic press;
    logic en;
  } enc_flags_t;

  typedef struct packed {
    logic [NUM_ENCODERS-1:0] cw;
    logic [NUM_ENCODERS-1:0] ccw;
    logic [NUM_ENCODERS-1:0] press;
    logic [NUM_ENCODERS-1:0] en;
  } result_t;

  // Gray-code direction: 00->01->11->10->00 is forward
  function automatic step_t gray_step(input logic [1:0] from_ab, input logic [1:0] to_ab);
    step_t s;
    case ({from_ab, to_ab}) inside
      4'b0001, 4'b0111, 4'b1000, 4'b1110: s = STEP_FWD;
      4'b0010, 4'b0100, 4'b1011, 4'b1101: s = STEP_REV;
      default:                            s = STEP_NONE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mqed_enc.sv
`default_nettype none

module mqed_enc
  import mqed_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic       init,
  input  wire logic [2:0] pins,
  input  wire cfg_t       cfg,
  output enc_flags_t      flags
);

  logic [1:0]        last_phase, last_phase_next;
  logic signed [3:0] step_acc, step_acc_next;
  logic              raw_switch, raw_switch_next;
  logic              settled_switch, settled_switch_next;
  logic [2:0]        run_count, run_count_next;
  logic              enabled, enabled_next;

  logic [1:0]        ab;
  logic              sw;
  step_t             step;
  logic signed [4:0] acc_sum;
  logic signed [4:0] detent_pos;
  logic signed [4:0] detent_neg;
  logic [2:0]        run_inc;

  assign ab         = {pins[0], pins[1]};
  assign sw         = pins[2];
  assign step       = gray_step(last_phase, ab);
  assign detent_pos = signed'({2'b00, cfg.detent_steps});
  assign detent_neg = -detent_pos;
  assign acc_sum    = signed'({step_acc[3], step_acc})
                    + ((step == STEP_FWD) ? 5'sd1 : -5'sd1);
  assign run_inc    = run_count + 3'd1;

  always_comb begin
    last_phase_next     = last_phase;
    step_acc_next       = step_acc;
    raw_switch_next     = raw_switch;
    settled_switch_next = settled_switch;
    run_count_next      = run_count;
    enabled_next        = enabled;
    flags               = '0;

    if (init) begin
      last_phase_next     = ab;
      step_acc_next       = '0;
      raw_switch_next     = sw;
      settled_switch_next = sw;
      run_count_next      = '0;
    end else begin
      last_phase_next = ab;
      if (step != STEP_NONE && enabled) begin
        if (acc_sum >= detent_pos) begin
          step_acc_next = '0;
          flags.cw      = 1'b1;
        end else if (acc_sum <= detent_neg) begin
          step_acc_next = '0;
          flags.ccw     = 1'b1;
        end else begin
          step_acc_next = acc_sum[3:0];
        end
      end

      if (sw != raw_switch) begin
        raw_switch_next = sw;
        run_count_next  = '0;
      end else if (run_count < cfg.debounce_samples) begin
        run_count_next = run_inc;
        if (run_inc >= cfg.debounce_samples && sw != settled_switch) begin
          settled_switch_next = sw;
          if (!sw) begin
            enabled_next = ~enabled;
            flags.press  = 1'b1;
          end
        end
      end
    end
    flags.en = enabled_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase     <= '0;
      step_acc       <= '0;
      raw_switch     <= 1'b1;
      settled_switch <= 1'b1;
      run_count      <= '0;
      enabled        <= 1'b0;
    end else if (accept) begin
      last_phase     <= last_phase_next;
      step_acc       <= step_acc_next;
      raw_switch     <= raw_switch_next;
      settled_switch <= settled_switch_next;
      run_count      <= run_count_next;
      enabled        <= enabled_next;
    end
  end

  // Sum clears on reaching a detent, so it stays within one detent of zero
  a_acc_bounded: assert property (@(posedge clk) disable iff (rst)
    step_acc != -4'sd8 && step_acc != -4'sd7 && step_acc != 4'sd7)
    else $error("step accumulator out of range");

  a_press_toggles: assert property (@(posedge clk) disable iff (rst)
    accept && flags.press |=> enabled != $past(enabled))
    else $error("press did not toggle enable");

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    !(flags.cw && flags.ccw))
    else $error("cw and ccw event together");

endmodule

`default_nettype wire

### hw/rtl/mqed_obuf.sv
`default_nettype none

module mqed_obuf
  import mqed_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t din,
  output result_t      dout,
  output logic         dout_valid,
  input  wire logic    dout_stall,
  output logic         full
);

  result_t skid;
  logic    skid_valid;
  logic    take;

  assign take = dout_valid && !dout_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load) begin
        if (!dout_valid || take) begin
          dout_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          dout_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (!dout_valid || take) begin
        dout <= din;
      end else begin
        skid <= din;
      end
    end else if (take && skid_valid) begin
      dout <= skid;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> dout_valid)
    else $error("skid holds an item while output is empty");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !load)
    else $error("item loaded while skid is full");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    skid_valid && take && !load |=> !skid_valid && dout_valid)
    else $error("skid item not moved to output");

endmodule

`default_nettype wire

### hw/rtl/multi_quadrature_encoder_debounce_core.sv
`default_nettype none

// Five-channel quadrature encoder decoder with push-switch debounce.
// Sample channel: sample_valid / sample_stall carry one item per pin sample,
//   req_type (0 = normal sample, 1 = initialize) and the 16-bit pin_sample.
//   Encoder i reads A at bit 3i, B at bit 3i+1 and its switch at bit 3i+2.
// Result channel: result_valid / result_stall carry one item per sample:
//   cw_events, ccw_events, press_events and enabled_flags (one bit each).
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
//   is detent_steps, index 1 is debounce_samples, other indexes are dropped.
//   cfg_ready is always high; write only while no item is in flight.
// Result timing: a result shows the cycle after its sample is accepted
//   when the result register is free, otherwise it waits in the skid entry.
// Throughput: one sample per cycle while sample_stall is low; all per-encoder
//   decode and debounce logic sits between encoder state and result registers.
// Stall: a two-entry output stage (result register plus skid) keeps taking
//   samples while one result waits; sample_stall rises only when both are full.
// Reset (rst, synchronous): registers go to 4, phases to 00, switches to
//   released, counters and enable flags to zero, and both channels empty.
module multi_quadrature_encoder_debounce_core
  import mqed_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,

  input  wire logic                    sample_valid,
  output logic                         sample_stall,
  input  wire logic                    req_type,
  input  wire logic [PIN_WIDTH-1:0]    pin_sample,

  output logic                         result_valid,
  input  wire logic                    result_stall,
  output logic [NUM_ENCODERS-1:0]      cw_events,
  output logic [NUM_ENCODERS-1:0]      ccw_events,
  output logic [NUM_ENCODERS-1:0]      press_events,
  output logic [NUM_ENCODERS-1:0]      enabled_flags,

  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [2:0]              cfg_data
);

  cfg_t       cfg;
  logic       accept;
  result_t    result_next;
  result_t    result;
  enc_flags_t flags [NUM_ENCODERS];

  // Configuration registers: always ready, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detent_steps     <= DETENT_RESET;
      cfg.debounce_samples <= DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DETENT_STEPS:     cfg.detent_steps     <= cfg_data;
        CFG_DEBOUNCE_SAMPLES: cfg.debounce_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  // Take a sample whenever the output stage has room
  assign accept = sample_valid && !sample_stall;

  // One decoder per encoder, each on its own three pins
  for (genvar i = 0; i < NUM_ENCODERS; i++) begin : g_enc
    mqed_enc u_enc (
      .clk    (clk),
      .rst    (rst),
      .accept (accept),
      .init   (req_type),
      .pins   (pin_sample[PINS_PER_ENC*i +: PINS_PER_ENC]),
      .cfg    (cfg),
      .flags  (flags[i])
    );

    assign result_next.cw[i]    = flags[i].cw;
    assign result_next.ccw[i]   = flags[i].ccw;
    assign result_next.press[i] = flags[i].press;
    assign result_next.en[i]    = flags[i].en;
  end

  // Result register with skid; its fullness drives the stall back
  mqed_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .din        (result_next),
    .dout       (result),
    .dout_valid (result_valid),
    .dout_stall (result_stall),
    .full       (sample_stall)
  );

  assign cw_events     = result.cw;
  assign ccw_events    = result.ccw;
  assign press_events  = result.press;
  assign enabled_flags = result.en;

  // An init item never reports a detent or a press
  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    accept && req_type |-> result_next.cw == '0 && result_next.ccw == '0
                           && result_next.press == '0)
    else $error("event flagged on init item");

  // After an accepted item, result_valid is high the next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted item produced no result");

  // Stall only when a result is already waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid)
    else $error("stall raised with empty output");

endmodule

`default_nettype wire

### verif/multi_quadrature_encoder_debounce_core_test.sv
`timescale 1ns / 100ps

// Five encoders share one pin word. Each sample item is checked against an
// in-bench decoder that tracks the phase, step sum, switch debounce and enable
// flag of every encoder. Configuration changes only while the block is idle.
module multi_quadrature_encoder_debounce_core_test;
  import mqed_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with no handshake at all
  localparam int LONG_HOLD   = 80;    // receiver hold-off that fills the output stage

  // Register indexes past the last one; the block must drop these writes
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic                 init_req;
    logic [PIN_WIDTH-1:0] pins;
  } sample_item_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #10 clk = ~clk;

  logic                    sample_valid = 1'b0;
  logic                    sample_stall;
  logic                    req_type = 1'b0;
  logic [PIN_WIDTH-1:0]    pin_sample = '0;

  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic [NUM_ENCODERS-1:0] cw_events;
  logic [NUM_ENCODERS-1:0] ccw_events;
  logic [NUM_ENCODERS-1:0] press_events;
  logic [NUM_ENCODERS-1:0] enabled_flags;

  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [1:0]              cfg_index = '0;
  logic [2:0]              cfg_data = '0;

  multi_quadrature_encoder_debounce_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_stall  (sample_stall),
    .req_type      (req_type),
    .pin_sample    (pin_sample),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .cw_events     (cw_events),
    .ccw_events    (ccw_events),
    .press_events  (press_events),
    .enabled_flags (enabled_flags),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Encoder decoder: per-encoder state plus the register copies
  // ---------------------------------------------------------------------------
  logic [2:0] detent_cfg;
  logic [2:0] debounce_cfg;
  logic [1:0] seen_phase [NUM_ENCODERS];
  int         step_sum   [NUM_ENCODERS];
  logic       sw_raw     [NUM_ENCODERS];
  logic       sw_settled [NUM_ENCODERS];
  int         sw_run     [NUM_ENCODERS];
  logic       enc_on     [NUM_ENCODERS];

  result_t      due_flags [$];     // flags owed by the block, oldest first
  sample_item_t samples_todo [$];  // items waiting for the driver

  int mismatches = 0;

  task automatic reset_decoder();
    detent_cfg   = DETENT_RESET;
    debounce_cfg = DEBOUNCE_RESET;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      seen_phase[i] = 2'b00;
      step_sum[i]   = 0;
      sw_raw[i]     = 1'b1;
      sw_settled[i] = 1'b1;
      sw_run[i]     = 0;
      enc_on[i]     = 1'b0;
    end
  endtask

  // Advance every encoder by one pin sample and return the flags it produces
  function automatic result_t decode_sample(input logic init_req,
                                            input logic [PIN_WIDTH-1:0] pins);
    result_t    r;
    logic [1:0] ab;
    logic [1:0] turn;
    logic       sw;
    step_t      dir;
    int         sum;
    r = '0;
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      ab = {pins[3*i], pins[3*i+1]};
      sw = pins[3*i+2];
      if (init_req) begin
        // Load phase and switch levels, clear counters, keep the enable flag
        seen_phase[i] = ab;
        sw_raw[i]     = sw;
        sw_settled[i] = sw;
        sw_run[i]     = 0;
        step_sum[i]   = 0;
      end else begin
        if (ab != seen_phase[i]) begin
          // Position on the Gray ring: 00, 01, 11, 10 map to 0, 1, 2, 3.
          // One place forward is a step up, one place back a step down,
          // a diagonal jump counts nothing.
          turn = {ab[1], ^ab} - {seen_phase[i][1], ^seen_phase[i]};
          dir  = (turn == 2'd1) ? STEP_FWD : (turn == 2'd3) ? STEP_REV : STEP_NONE;
          seen_phase[i] = ab;
          if (dir != STEP_NONE && enc_on[i]) begin
            sum = step_sum[i] + ((dir == STEP_FWD) ? 1 : -1);
            if (sum >= int'(detent_cfg)) begin
              sum      = 0;
              r.cw[i]  = 1'b1;
            end else if (sum <= -int'(detent_cfg)) begin
              sum      = 0;
              r.ccw[i] = 1'b1;
            end
            step_sum[i] = sum;
          end
        end
        // Restart the run on any switch change; settle once the run is long
        // enough, and toggle the enable on a settled press (level low).
        if (sw != sw_raw[i]) begin
          sw_raw[i] = sw;
          sw_run[i] = 0;
        end else if (sw_run[i] < int'(debounce_cfg)) begin
          sw_run[i]++;
          if (sw_run[i] >= int'(debounce_cfg) && sw != sw_settled[i]) begin
            sw_settled[i] = sw;
            if (!sw) begin
              enc_on[i]  = !enc_on[i];
              r.press[i] = 1'b1;
            end
          end
        end
      end
      r.en[i] = enc_on[i];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample driver: present queued items, predict on every accepted one
  // ---------------------------------------------------------------------------
  logic src_idle_on  = 1'b0;
  logic sink_idle_on = 1'b0;
  int   src_gap      = 0;

  always @(posedge clk) begin : drive_samples
    sample_item_t nxt;
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        due_flags.push_back(decode_sample(req_type, pin_sample));
      end
      // Hold the payload while stalled; otherwise idle or advance to the next item
      if (!sample_valid || !sample_stall) begin
        if (src_gap > 0) begin
          src_gap--;
          sample_valid <= 1'b0;
        end else if (src_idle_on && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(0, 12);
          sample_valid <= 1'b0;
        end else if (samples_todo.size() != 0) begin
          nxt = samples_todo.pop_front();
          sample_valid <= 1'b1;
          req_type     <= nxt.init_req;
          pin_sample   <= nxt.pins;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: check each accepted result, then drive the stall
  // ---------------------------------------------------------------------------
  logic hold_armed = 1'b0;  // set once by the sequencer
  logic hold_done  = 1'b0;
  int   hold_left  = 0;
  int   sink_gap   = 0;

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin : watch_results
    result_t got;
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        got = {cw_events, ccw_events, press_events, enabled_flags};
        if (due_flags.size() == 0) begin
          report($sformatf("result with nothing pending: %h", got));
        end else begin
          want = due_flags.pop_front();
          if (got.cw !== want.cw)
            report($sformatf("cw_events expected %b, got %b", want.cw, got.cw));
          if (got.ccw !== want.ccw)
            report($sformatf("ccw_events expected %b, got %b", want.ccw, got.ccw));
          if (got.press !== want.press)
            report($sformatf("press_events expected %b, got %b", want.press, got.press));
          if (got.en !== want.en)
            report($sformatf("enabled_flags expected %b, got %b", want.en, got.en));
        end
      end
      // Start the long hold-off once when armed; it outranks the short bursts
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        result_stall <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 12);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no channel moves for too long
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: knob positions on the Gray ring and switch levels per encoder
  // ---------------------------------------------------------------------------
  logic [1:0] knob_pos [NUM_ENCODERS];
  logic       knob_sw  [NUM_ENCODERS];
  logic       knob_fwd [NUM_ENCODERS];  // preferred turning direction

  task automatic push_item(input logic init_req, input logic [PIN_WIDTH-1:0] pins);
    samples_todo.push_back('{init_req: init_req, pins: pins});
  endtask

  // Build the pin word from the knobs; bit 15 is unused and gets noise
  function automatic logic [PIN_WIDTH-1:0] knob_word();
    logic [PIN_WIDTH-1:0] w;
    w = '0;
    w[PIN_WIDTH-1] = 1'($urandom_range(0, 1));
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      w[3*i]   = knob_pos[i][1];
      w[3*i+1] = knob_pos[i][1] ^ knob_pos[i][0];
      w[3*i+2] = knob_sw[i];
    end
    return w;
  endfunction

  task automatic set_knobs(input logic [1:0] pos, input logic sw);
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      knob_pos[i] = pos;
      knob_sw[i]  = sw;
    end
  endtask

  // Mostly legal turning with switch presses of random length; a few
  // diagonal jumps, re-inits and raw noise words in between.
  task automatic queue_motion(input int count);
    int pick;
    int move;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        push_item($urandom_range(0, 3) == 0, PIN_WIDTH'($urandom));
      end else if (pick < 9) begin
        push_item(1'b1, knob_word());
      end else begin
        for (int i = 0; i < NUM_ENCODERS; i++) begin
          move = $urandom_range(0, 19);
          if (move < 9)
            knob_pos[i] = knob_pos[i] + (knob_fwd[i] ? 2'd1 : 2'd3);
          else if (move < 12)
            knob_pos[i] = knob_pos[i] + (knob_fwd[i] ? 2'd3 : 2'd1);
          else if (move == 12)
            knob_pos[i] = knob_pos[i] + 2'd2;
          else if (move == 13)
            knob_fwd[i] = !knob_fwd[i];
          if ($urandom_range(0, 9) == 0) knob_sw[i] = !knob_sw[i];
        end
        push_item(1'b0, knob_word());
      end
    end
  endtask

  // Wait until every item went in and every result came out, then settle
  task automatic drain();
    while (samples_todo.size() != 0 || sample_valid || due_flags.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one register and wait for the handshake; valid stays up for the
  // next write and is dropped by the caller after the last one.
  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_DETENT_STEPS)
      detent_cfg = val;
    else if (idx == CFG_DEBOUNCE_SAMPLES)
      debounce_cfg = val;
  endtask

  // Idle the block, program both registers plus a dropped index, queue items
  task automatic run_phase(input logic [2:0] det, input logic [2:0] deb, input int count,
                           input logic src_idle, input logic sink_idle);
    drain();
    src_idle_on  <= src_idle;
    sink_idle_on <= sink_idle;
    write_reg(CFG_DETENT_STEPS, det);
    write_reg(CFG_DEBOUNCE_SAMPLES, deb);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 3'($urandom_range(0, 7)));
    cfg_valid <= 1'b0;
    queue_motion(count);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    reset_decoder();
    for (int i = 0; i < NUM_ENCODERS; i++) begin
      knob_fwd[i] = 1'($urandom_range(0, 1));
    end
    repeat (6) @(posedge clk);
    rst          <= 1'b0;
    src_idle_on  <= 1'b1;
    sink_idle_on <= 1'b1;

    // Directed part at reset settings (detent 4, debounce 4).
    // Sync all encoders to phase 00 with switches released.
    set_knobs(2'd0, 1'b1);
    push_item(1'b1, knob_word());
    // Hold every switch down until it settles: press, enables go on
    set_knobs(2'd0, 1'b0);
    repeat (5) push_item(1'b0, knob_word());
    // Release while turning one full detent forward: clockwise event
    for (int k = 1; k <= 4; k++) begin
      set_knobs(2'(k), 1'b1);
      push_item(1'b0, knob_word());
    end
    // One full detent backward: counter-clockwise event
    for (int k = 3; k >= 0; k--) begin
      set_knobs(2'(k), 1'b1);
      push_item(1'b0, knob_word());
    end
    // Diagonal jump counts nothing, then a steady phase keeps the sum
    set_knobs(2'd2, 1'b1);
    repeat (2) push_item(1'b0, knob_word());
    // Init with switches down: enables kept, no press
    set_knobs(2'd1, 1'b0);
    push_item(1'b1, knob_word());
    // Extremes of the pin word
    push_item(1'b0, 16'hFFFF);
    push_item(1'b0, 16'h0000);
    push_item(1'b1, 16'h8000);
    push_item(1'b0, 16'h7FFF);

    // Random part across several register settings
    run_phase(3'd1, 3'd1, 70, 1'b1, 1'b1);
    run_phase(3'd7, 3'd7, 70, 1'b1, 1'b0);
    // Zero detent: an enabled encoder flags every legal step; zero debounce: never settles.
    // Counts left from the previous phase now sit above the registers.
    run_phase(3'd0, 3'd0, 40, 1'b0, 1'b1);
    // Pressure: keep offering items while the receiver holds off
    run_phase(3'd2, 3'd3, 70, 1'b0, 1'b0);
    hold_armed <= 1'b1;
    run_phase(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 60, 1'b1, 1'b1);
    run_phase(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 60, 1'b1, 1'b1);
    // Last stretch runs at full rate on both sides
    run_phase(3'd3, 3'd2, 60, 1'b0, 1'b0);
    drain();

    if (mismatches == 0 && due_flags.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
